// ----- design/event_driven_lif_neuron_array_defines.svh -----
// Assertion macros used by the neuron array RTL.
`ifndef EVENT_DRIVEN_LIF_NEURON_ARRAY_DEFINES_SVH
`define EVENT_DRIVEN_LIF_NEURON_ARRAY_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define EDLIF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("neuron array assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define EDLIF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("neuron array assertion failed");

`endif

// ----- design/edlif_pkg.sv -----
// Shared types and constants for the event-driven neuron array.
package edlif_pkg;

   localparam int NEURON_COUNT = 1024;
   localparam int NEURON_IDX_W = $clog2(NEURON_COUNT);

   localparam int ID_W        = 10;
   localparam int WEIGHT_W    = 8;
   localparam int GROUP_W     = 4;
   localparam int EXTRA_W     = 42;
   localparam int WORD_W      = 64;
   localparam int MEMBRANE_W  = 16;
   localparam int TIMER_W     = 8;
   localparam int SHIFT_W     = 4;
   localparam int COUNT_W     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [GROUP_W-1:0] FORWARD_GROUP = 4'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRE_THRESHOLD    = 2'd0,
      CSR_LEAK_SHIFT        = 2'd1,
      CSR_REFRACTORY_PERIOD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                         refractory;
      logic [TIMER_W-1:0]           timer;
      logic signed [MEMBRANE_W-1:0] membrane;
   } neuron_state_type;

   typedef struct packed {
      logic               fired;
      logic [ID_W-1:0]    spike_neuron;
      logic [GROUP_W-1:0] spike_group;
      logic               forward;
      logic [WORD_W-1:0]  forward_word;
      logic [COUNT_W-1:0] spike_total;
   } result_type;

endpackage

// ----- design/edlif_if.sv -----
// Channel interfaces for events, results and register writes.
interface edlif_req_if
   import edlif_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [ID_W-1:0]            neuron_id;
   logic signed [WEIGHT_W-1:0] weight;
   logic [GROUP_W-1:0]         group;
   logic [EXTRA_W-1:0]         extra_bits;

   modport source (output valid, neuron_id, weight, group, extra_bits, input ready);
   modport sink   (input valid, neuron_id, weight, group, extra_bits, output ready);
endinterface

interface edlif_rsp_if
   import edlif_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               fired;
   logic [ID_W-1:0]    spike_neuron;
   logic [GROUP_W-1:0] spike_group;
   logic               forward;
   logic [WORD_W-1:0]  forward_word;
   logic [COUNT_W-1:0] spike_total;

   modport source (output valid, fired, spike_neuron, spike_group, forward, forward_word,
                   spike_total, input ready);
   modport sink   (input valid, fired, spike_neuron, spike_group, forward, forward_word,
                   spike_total, output ready);
endinterface

interface edlif_csr_if
   import edlif_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/event_driven_lif_neuron_array.sv -----
// Top level of the event-driven leaky integrate-and-fire neuron array.
//
//   Channel  Direction  Carries
//   req_if   in         neuron_id, weight, group, extra_bits
//   rsp_if   out        fired, spike_neuron, spike_group, forward, forward_word, spike_total
//   csr_if   in         index, data (threshold, leak shift, refractory period)
//
// One event per cycle while rsp_if is ready; the read stage feeds the output register.
// The rate is set by the single neuron state memory: one read and one write per cycle.
// After reset the memory is cleared one entry per cycle, all NEURON_COUNT entries in turn,
// during which no event transaction is taken; register writes are taken at any time.
// A stalled response holds the pipeline; the next event is taken as the response leaves.
`include "event_driven_lif_neuron_array_defines.svh"

module event_driven_lif_neuron_array
   import edlif_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   edlif_req_if.sink   req_if,
   edlif_rsp_if.source rsp_if,
   edlif_csr_if.sink   csr_if
);

   neuron_state_type state_mem [NEURON_COUNT];

   logic [MEMBRANE_W-1:0]   threshold_ff;
   logic [SHIFT_W-1:0]      leak_shift_ff;
   logic [TIMER_W-1:0]      period_ff;

   logic                    clear_done_ff;
   logic [NEURON_IDX_W-1:0] clear_idx_ff;
   logic [NEURON_IDX_W-1:0] clear_idx_in;

   logic                       s1_valid_ff;
   logic [ID_W-1:0]            s1_id_ff;
   logic signed [WEIGHT_W-1:0] s1_weight_ff;
   logic [GROUP_W-1:0]         s1_group_ff;
   logic [EXTRA_W-1:0]         s1_extra_ff;
   logic                       s1_in_range_ff;
   neuron_state_type           rd_state_ff;

   logic                    fwd_valid_ff;
   logic [NEURON_IDX_W-1:0] fwd_idx_ff;
   neuron_state_type        fwd_state_ff;

   logic [COUNT_W-1:0] fire_count_ff;
   logic [COUNT_W-1:0] fire_count_in;

   logic       out_valid_ff;
   result_type out_result_ff;
   result_type out_result_in;

   logic                           req_accept;
   logic                           s1_advance;
   logic [NEURON_IDX_W-1:0]        req_idx;
   logic [NEURON_IDX_W-1:0]        s1_idx;
   logic                           req_in_range;
   logic                           wr_en;
   neuron_state_type               cur_state;
   neuron_state_type               next_state;
   logic signed [MEMBRANE_W-1:0]   leak_amt;
   logic signed [MEMBRANE_W-1:0]   integ;
   logic signed [MEMBRANE_W:0]     integ_wide;
   logic signed [MEMBRANE_W:0]     threshold_wide;
   logic                           fire_hit;
   logic                           is_forward;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= '0;
         leak_shift_ff <= '0;
         period_ff     <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_FIRE_THRESHOLD:    threshold_ff  <= csr_if.data;
            CSR_LEAK_SHIFT:        leak_shift_ff <= csr_if.data[SHIFT_W-1:0];
            CSR_REFRACTORY_PERIOD: period_ff     <= csr_if.data[TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   assign clear_idx_in = clear_idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_done_ff <= 1'b0;
         clear_idx_ff  <= '0;
      end else if (!clear_done_ff) begin
         clear_idx_ff <= clear_idx_in;
         if (clear_idx_ff == NEURON_IDX_W'(NEURON_COUNT - 1)) begin
            clear_done_ff <= 1'b1;
         end
      end
   end

   assign s1_advance    = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = clear_done_ff && (!s1_valid_ff || s1_advance);
   assign req_accept    = req_if.valid && req_if.ready;
   assign req_idx       = req_if.neuron_id[NEURON_IDX_W-1:0];
   assign req_in_range  = {1'b0, req_if.neuron_id} < (ID_W + 1)'(NEURON_COUNT);
   assign s1_idx        = s1_id_ff[NEURON_IDX_W-1:0];
   assign wr_en         = s1_advance && s1_in_range_ff;

   always_ff @(posedge clock) begin
      if (!clear_done_ff) begin
         state_mem[clear_idx_ff] <= '0;
      end else if (wr_en) begin
         state_mem[s1_idx] <= next_state;
      end
      if (req_accept) begin
         rd_state_ff <= state_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_id_ff       <= req_if.neuron_id;
         s1_weight_ff   <= req_if.weight;
         s1_group_ff    <= req_if.group;
         s1_extra_ff    <= req_if.extra_bits;
         s1_in_range_ff <= req_in_range;
      end
   end

   // The write of the leaving event lands on the same edge as the read of the next one,
   // so the last written entry is kept and replaces stale read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         fwd_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_idx_ff   <= s1_idx;
         fwd_state_ff <= next_state;
      end
   end

   always_comb begin
      cur_state = rd_state_ff;
      if (fwd_valid_ff && (fwd_idx_ff == s1_idx)) begin
         cur_state = fwd_state_ff;
      end
   end

   assign leak_amt       = cur_state.membrane >>> leak_shift_ff;
   assign integ          = cur_state.membrane - leak_amt + MEMBRANE_W'(s1_weight_ff);
   assign integ_wide     = {integ[MEMBRANE_W-1], integ};
   assign threshold_wide = {1'b0, threshold_ff};
   assign fire_hit       = s1_in_range_ff && !cur_state.refractory
                           && (integ_wide >= threshold_wide);

   always_comb begin
      next_state = cur_state;
      priority if (cur_state.refractory) begin
         if (cur_state.timer >= period_ff) begin
            next_state.refractory = 1'b0;
         end else begin
            next_state.timer = cur_state.timer + 1'b1;
         end
      end else if (fire_hit) begin
         next_state.refractory = 1'b1;
         next_state.timer      = '0;
         next_state.membrane   = '0;
      end else begin
         next_state.membrane = integ;
      end
   end

   assign fire_count_in = fire_count_ff + COUNT_W'(fire_hit);
   assign is_forward    = (s1_group_ff == FORWARD_GROUP);

   always_comb begin
      out_result_in.fired        = fire_hit;
      out_result_in.spike_neuron = fire_hit ? s1_id_ff : '0;
      out_result_in.spike_group  = fire_hit ? s1_group_ff : '0;
      out_result_in.forward      = is_forward;
      out_result_in.forward_word = is_forward
                                   ? {s1_extra_ff, s1_group_ff, s1_weight_ff, s1_id_ff} : '0;
      out_result_in.spike_total  = fire_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fire_count_ff <= '0;
      end else if (s1_advance) begin
         fire_count_ff <= fire_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_result_ff <= out_result_in;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.fired        = out_result_ff.fired;
   assign rsp_if.spike_neuron = out_result_ff.spike_neuron;
   assign rsp_if.spike_group  = out_result_ff.spike_group;
   assign rsp_if.forward      = out_result_ff.forward;
   assign rsp_if.forward_word = out_result_ff.forward_word;
   assign rsp_if.spike_total  = out_result_ff.spike_total;

   `EDLIF_ASSERT_SAME(a_no_event_during_clear, !clear_done_ff, !req_accept && !s1_valid_ff)
   `EDLIF_ASSERT_SAME(a_refractory_never_fires, s1_valid_ff && cur_state.refractory, !fire_hit)
   `EDLIF_ASSERT_NEXT(a_count_follows_fire, s1_advance && fire_hit,
                      fire_count_ff == $past(fire_count_ff) + 1'b1)
   `EDLIF_ASSERT_SAME(a_forward_group_matches, out_valid_ff && out_result_ff.forward,
                      out_result_ff.forward_word[21:18] == FORWARD_GROUP)
   `EDLIF_ASSERT_NEXT(a_idle_stage_keeps_count, !s1_advance, $stable(fire_count_ff))

endmodule

// ----- tb/tb_event_driven_lif_neuron_array.sv -----
// Self-checking testbench for the event-driven leaky integrate-and-fire neuron array.
module tb_event_driven_lif_neuron_array;
   import edlif_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REGISTER = 2'd3;

   typedef struct packed {
      logic [EXTRA_W-1:0]         extra_bits;
      logic [GROUP_W-1:0]         group;
      logic signed [WEIGHT_W-1:0] weight;
      logic [ID_W-1:0]            neuron_id;
   } spike_event_type;

   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] csr_index;
      logic [CSR_DATA_W-1:0]  csr_data;
      spike_event_type        ev;
      bit                     typed;
      result_type             expected;
   } stim_row_type;

   typedef enum {
      PHASE_MIXED,
      PHASE_LONG_REFRACTORY,
      PHASE_WRAP,
      PHASE_FULL
   } phase_type;

   logic clock;
   logic reset;

   edlif_req_if req_if ();
   edlif_rsp_if rsp_if ();
   edlif_csr_if csr_if ();

   event_driven_lif_neuron_array dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   logic signed [MEMBRANE_W-1:0] membrane_model [NEURON_COUNT];
   logic [TIMER_W-1:0]           timer_model [NEURON_COUNT];
   bit                           refractory_model [NEURON_COUNT];
   logic [COUNT_W-1:0]           fire_count_model;
   logic [MEMBRANE_W-1:0]        threshold_cfg;
   logic [SHIFT_W-1:0]           leak_cfg;
   logic [TIMER_W-1:0]           period_cfg;

   result_type   awaited_results [$];
   stim_row_type directed_rows [$];
   int unsigned  error_count;
   int unsigned  cycle_count;
   int unsigned  burst_left;
   int unsigned  rsp_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  awaited_results.size());
         $display("** event_driven_lif_neuron_array: FAILED **");
         $finish;
      end
   end

   function automatic result_type integrate_event(input spike_event_type ev);
      result_type                   res;
      logic signed [MEMBRANE_W-1:0] level;
      int unsigned                  id;
      res = '0;
      id  = 32'(ev.neuron_id);
      if (id < NEURON_COUNT) begin
         if (!refractory_model[id]) begin
            level = membrane_model[id];
            level = level - (level >>> leak_cfg);
            level = level + {{(MEMBRANE_W-WEIGHT_W){ev.weight[WEIGHT_W-1]}}, ev.weight};
            if (int'(level) >= int'(threshold_cfg)) begin
               membrane_model[id]   = '0;
               refractory_model[id] = 1'b1;
               timer_model[id]      = '0;
               fire_count_model     = fire_count_model + 1;
               res.fired            = 1'b1;
               res.spike_neuron     = ev.neuron_id;
               res.spike_group      = ev.group;
            end else begin
               membrane_model[id] = level;
            end
         end else if (timer_model[id] >= period_cfg) begin
            refractory_model[id] = 1'b0;
         end else begin
            timer_model[id] = timer_model[id] + 1'b1;
         end
      end
      if (ev.group == FORWARD_GROUP) begin
         res.forward      = 1'b1;
         res.forward_word = {ev.extra_bits, ev.group, ev.weight, ev.neuron_id};
      end
      res.spike_total = fire_count_model;
      return res;
   endfunction

   function automatic result_type outcome(input logic fired, input logic [ID_W-1:0] neuron,
                                          input logic [GROUP_W-1:0] group, input logic fwd,
                                          input logic [WORD_W-1:0] word,
                                          input logic [COUNT_W-1:0] total);
      result_type res;
      res.fired        = fired;
      res.spike_neuron = neuron;
      res.spike_group  = group;
      res.forward      = fwd;
      res.forward_word = word;
      res.spike_total  = total;
      return res;
   endfunction

   function automatic stim_row_type event_row(input logic [ID_W-1:0] id,
                                              input logic [WEIGHT_W-1:0] weight,
                                              input logic [GROUP_W-1:0] group,
                                              input logic [EXTRA_W-1:0] extra,
                                              input bit typed, input result_type expected);
      stim_row_type row;
      row.is_csr        = 1'b0;
      row.csr_index     = '0;
      row.csr_data      = '0;
      row.ev.neuron_id  = id;
      row.ev.weight     = weight;
      row.ev.group      = group;
      row.ev.extra_bits = extra;
      row.typed         = typed;
      row.expected      = expected;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_W-1:0] index,
                                            input logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row           = event_row('0, '0, '0, '0, 1'b0, '0);
      row.is_csr    = 1'b1;
      row.csr_index = index;
      row.csr_data  = data;
      return row;
   endfunction

   function automatic spike_event_type random_event(input phase_type phase);
      spike_event_type ev;
      logic [63:0]     bits;
      bits          = {$urandom, $urandom};
      ev.extra_bits = bits[EXTRA_W-1:0];
      ev.group      = ($urandom_range(3) == 0) ? FORWARD_GROUP : GROUP_W'($urandom_range(15));
      ev.weight     = WEIGHT_W'($urandom_range(255));
      ev.neuron_id  = ID_W'($urandom_range(NEURON_COUNT - 1));
      case (phase)
         PHASE_MIXED: begin
            if ($urandom_range(4) != 0) ev.neuron_id = ID_W'($urandom_range(7));
         end
         PHASE_LONG_REFRACTORY: begin
            ev.neuron_id = ID_W'($urandom_range(3));
         end
         PHASE_WRAP: begin
            if ($urandom_range(31) != 0) ev.neuron_id = ID_W'(9);
            if ($urandom_range(15) != 0) ev.weight = WEIGHT_W'($urandom_range(127, 120));
         end
         default: begin
         end
      endcase
      return ev;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
   endtask

   always @(posedge clock) begin : response_monitor
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("response transaction with no event awaiting it");
         end else begin
            want = awaited_results.pop_front();
            check_field("fired", 64'(rsp_if.fired), 64'(want.fired));
            check_field("spike_neuron", 64'(rsp_if.spike_neuron), 64'(want.spike_neuron));
            check_field("spike_group", 64'(rsp_if.spike_group), 64'(want.spike_group));
            check_field("forward", 64'(rsp_if.forward), 64'(want.forward));
            check_field("forward_word", rsp_if.forward_word, want.forward_word);
            check_field("spike_total", 64'(rsp_if.spike_total), 64'(want.spike_total));
         end
      end
   end

   initial begin : response_receiver
      int unsigned mode;
      int unsigned mode_left;
      mode      = 0;
      mode_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(2);
               mode_left = $urandom_range(60, 10);
            end
            mode_left--;
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(1) == 0);
               default: rsp_if.ready <= ($urandom_range(3) == 0);
            endcase
         end
      end
   end

   task automatic offer_event(input spike_event_type ev, input bit typed,
                              input result_type typed_result);
      result_type predicted;
      req_if.valid      <= 1'b1;
      req_if.neuron_id  <= ev.neuron_id;
      req_if.weight     <= ev.weight;
      req_if.group      <= ev.group;
      req_if.extra_bits <= ev.extra_bits;
      do @(posedge clock); while (!req_if.ready);
      predicted = integrate_event(ev);
      awaited_results.push_back(typed ? typed_result : predicted);
      @(negedge clock);
   endtask

   task automatic idle_between_events();
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      case (csr_index_type'(index))
         CSR_FIRE_THRESHOLD:    threshold_cfg = data;
         CSR_LEAK_SHIFT:        leak_cfg      = data[SHIFT_W-1:0];
         CSR_REFRACTORY_PERIOD: period_cfg    = data[TIMER_W-1:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   initial begin : stimulus
      phase_type   phase_plan [5];
      int unsigned phase_items [5];
      spike_event_type ev;
      phase_plan  = '{PHASE_MIXED, PHASE_LONG_REFRACTORY, PHASE_WRAP, PHASE_FULL, PHASE_MIXED};
      phase_items = '{45, 50, 330, 80, 45};

      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.neuron_id  = '0;
      req_if.weight     = '0;
      req_if.group      = '0;
      req_if.extra_bits = '0;
      csr_if.valid      = 1'b0;
      csr_if.index      = '0;
      csr_if.data       = '0;
      error_count       = 0;
      cycle_count       = 0;
      burst_left        = 0;
      rsp_hold_cycles   = 0;
      fire_count_model  = '0;
      threshold_cfg     = '0;
      leak_cfg          = '0;
      period_cfg        = '0;
      for (int i = 0; i < NEURON_COUNT; i++) begin
         membrane_model[i]   = '0;
         timer_model[i]      = '0;
         refractory_model[i] = 1'b0;
      end

      // Reset values: zero threshold, full leak, zero refractory period.
      directed_rows.push_back(event_row(10'd0, 8'h00, 4'd0, '0, 1'b1,
                                        outcome(1'b1, 10'd0, 4'd0, 1'b0, '0, 32'd1)));
      directed_rows.push_back(event_row(10'd0, 8'h05, 4'd0, '0, 1'b1,
                                        outcome(1'b0, '0, '0, 1'b0, '0, 32'd1)));
      directed_rows.push_back(event_row(10'h3FF, 8'h80, FORWARD_GROUP, 42'h3FF_FFFF_FFFF, 1'b1,
                                        outcome(1'b0, '0, '0, 1'b1,
                                                {42'h3FF_FFFF_FFFF, FORWARD_GROUP, 8'h80,
                                                 10'h3FF}, 32'd1)));
      directed_rows.push_back(event_row(10'h3FF, 8'hFF, 4'd15, 42'h155_5555_5555, 1'b1,
                                        outcome(1'b0, '0, '0, 1'b0, '0, 32'd1)));
      directed_rows.push_back(event_row(10'd0, 8'h7F, 4'd15, 42'h2AA_AAAA_AAAA, 1'b1,
                                        outcome(1'b1, 10'd0, 4'd15, 1'b0, '0, 32'd2)));
      directed_rows.push_back(event_row(10'h3FF, 8'h00, FORWARD_GROUP, '0, 1'b1,
                                        outcome(1'b1, 10'h3FF, FORWARD_GROUP, 1'b1,
                                                {42'd0, FORWARD_GROUP, 8'h00, 10'h3FF},
                                                32'd3)));
      // Unreachable threshold, wide values that must be truncated, and an unused index.
      directed_rows.push_back(csr_row(CSR_FIRE_THRESHOLD, 16'hFFFF));
      directed_rows.push_back(csr_row(CSR_LEAK_SHIFT, 16'hFFFF));
      directed_rows.push_back(csr_row(CSR_REFRACTORY_PERIOD, 16'hAB03));
      directed_rows.push_back(csr_row(CSR_NO_REGISTER, 16'h1234));
      directed_rows.push_back(event_row(10'd2, 8'h7F, FORWARD_GROUP, 42'h155_5555_5555, 0, '0));
      directed_rows.push_back(event_row(10'd2, 8'h7F, 4'd1, 42'h0FF_00FF_00FF, 0, '0));
      directed_rows.push_back(event_row(10'd2, 8'h80, 4'd2, '0, 0, '0));
      directed_rows.push_back(event_row(10'd2, 8'h80, 4'd8, '0, 0, '0));
      // Zero threshold with a gentle leak, then a full refractory cycle of period three.
      directed_rows.push_back(csr_row(CSR_FIRE_THRESHOLD, 16'h0000));
      directed_rows.push_back(csr_row(CSR_LEAK_SHIFT, 16'h0001));
      directed_rows.push_back(event_row(10'd3, 8'hFF, 4'd0, '0, 0, '0));
      directed_rows.push_back(event_row(10'd3, 8'h01, 4'd3, '0, 0, '0));
      for (int i = 0; i < 5; i++)
         directed_rows.push_back(event_row(10'd3, 8'h00, FORWARD_GROUP, '0, 0, '0));
      directed_rows.push_back(csr_row(CSR_FIRE_THRESHOLD, 16'h7FFF));
      directed_rows.push_back(csr_row(CSR_LEAK_SHIFT, 16'h0000));
      directed_rows.push_back(csr_row(CSR_REFRACTORY_PERIOD, 16'h00FF));
      directed_rows.push_back(event_row(10'd4, 8'h7F, 4'd6, '0, 0, '0));
      directed_rows.push_back(event_row(10'd4, 8'h80, 4'd9, '0, 0, '0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            write_register(directed_rows[i].csr_index, directed_rows[i].csr_data);
         end else begin
            offer_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].expected);
            idle_between_events();
         end
      end

      for (int p = 0; p < 5; p++) begin
         case (phase_plan[p])
            PHASE_MIXED: begin
               write_register(CSR_FIRE_THRESHOLD, CSR_DATA_W'($urandom_range(200)));
               write_register(CSR_LEAK_SHIFT, CSR_DATA_W'($urandom_range(15)));
               write_register(CSR_REFRACTORY_PERIOD, CSR_DATA_W'($urandom_range(7)));
            end
            PHASE_LONG_REFRACTORY: begin
               write_register(CSR_FIRE_THRESHOLD, 16'h0000);
               write_register(CSR_LEAK_SHIFT, 16'h0000);
               write_register(CSR_REFRACTORY_PERIOD, 16'h00FF);
            end
            PHASE_WRAP: begin
               write_register(CSR_FIRE_THRESHOLD, 16'hFFFF);
               write_register(CSR_LEAK_SHIFT, 16'h000F);
               write_register(CSR_REFRACTORY_PERIOD, 16'h0000);
            end
            default: begin
               write_register(CSR_FIRE_THRESHOLD, ($urandom_range(1) == 0) ?
                              CSR_DATA_W'($urandom_range(400)) :
                              CSR_DATA_W'($urandom_range(65535)));
               write_register(CSR_LEAK_SHIFT, CSR_DATA_W'($urandom_range(65535)));
               write_register(CSR_REFRACTORY_PERIOD, CSR_DATA_W'($urandom_range(65535)));
            end
         endcase
         for (int i = 0; i < phase_items[p]; i++) begin
            if (p == 0 && i == 5) rsp_hold_cycles = 64;
            ev = random_event(phase_plan[p]);
            offer_event(ev, 1'b0, '0);
            if (phase_plan[p] == PHASE_FULL && i == phase_items[p] / 2)
               drain_results();
            else
               idle_between_events();
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("** event_driven_lif_neuron_array: PASSED **");
      else
         $display("** event_driven_lif_neuron_array: FAILED **");
      $finish;
   end

endmodule
